// ----- rtl/core/potb_pkg.sv -----
// ----------------------------------------------------------------------------
// potb_pkg: shared types and constants of the timer bank
// Slot count, command and status codes, and the layout of one stored slot.
// ----------------------------------------------------------------------------
package potb_pkg;

  localparam int NumTimers = 16;
  localparam int IdxW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;

  localparam int CmdW    = 2;
  localparam int SlotW   = 4;
  localparam int PeriodW = 32;
  localparam int StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CmdTick  = 2'd0,
    CmdInit  = 2'd1,
    CmdStart = 2'd2,
    CmdStop  = 2'd3
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    StOk         = 2'd0,
    StZeroPeriod = 2'd1,
    StUninit     = 2'd2
  } status_e;

  typedef struct packed {
    logic [PeriodW-1:0] rem;
    logic [PeriodW-1:0] per;
    logic               rep;
    logic               run;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

  typedef struct packed {
    logic [CmdW-1:0]    cmd;
    logic [SlotW-1:0]   slot;
    logic               repeat_mode;
    logic [PeriodW-1:0] period_ticks;
  } item_t;

  typedef struct packed {
    logic               valid;
    logic [StatusW-1:0] status;
    logic               expired;
    logic [SlotW-1:0]   expired_slot;
    logic               last;
  } res_t;

endpackage

// ----- rtl/core/potb_in_if.sv -----
// ----------------------------------------------------------------------------
// potb_in_if: command channel
// Valid/ready channel carrying one timer command per transfer.
// ----------------------------------------------------------------------------
interface potb_in_if;
  logic                         valid;
  logic                         ready;
  logic [potb_pkg::CmdW-1:0]    cmd;
  logic [potb_pkg::SlotW-1:0]   slot;
  logic                         repeat_mode;
  logic [potb_pkg::PeriodW-1:0] period_ticks;

  modport source (output valid, output cmd, output slot, output repeat_mode,
                  output period_ticks, input ready);
  modport sink (input valid, input cmd, input slot, input repeat_mode,
                input period_ticks, output ready);
endinterface

// ----- rtl/core/potb_out_if.sv -----
// ----------------------------------------------------------------------------
// potb_out_if: result channel
// Valid/ready channel carrying one status or expiry result per transfer.
// ----------------------------------------------------------------------------
interface potb_out_if;
  logic                         valid;
  logic                         ready;
  logic [potb_pkg::StatusW-1:0] status;
  logic                         expired;
  logic [potb_pkg::SlotW-1:0]   expired_slot;
  logic                         last;

  modport source (output valid, output status, output expired,
                  output expired_slot, output last, input ready);
  modport sink (input valid, input status, input expired, input expired_slot,
                input last, output ready);
endinterface

// ----- rtl/core/potb_ram.sv -----
// ----------------------------------------------------------------------------
// potb_ram: generic single-write, single-read RAM
// Registered read port; read data holds while no read is issued.
// ----------------------------------------------------------------------------
module potb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  logic [Width-1:0] wr_data_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output logic [Width-1:0] rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/potb_outbuf.sv -----
// ----------------------------------------------------------------------------
// potb_outbuf: result output register
// Holds one result until the sink takes it; frees when the transfer occurs.
// ----------------------------------------------------------------------------
module potb_outbuf (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  potb_pkg::res_t    push_i,
  output logic              can_push_o,
  potb_out_if.source        out_o
);

  logic           vld_q, vld_d;
  potb_pkg::res_t res_q;

  assign can_push_o = !vld_q || out_o.ready;

  always_comb begin
    vld_d = vld_q;
    if (push_i.valid && can_push_o) begin
      vld_d = 1'b1;
    end else if (out_o.ready) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.valid && can_push_o) begin
      res_q <= push_i;
    end
  end

  assign out_o.valid        = vld_q;
  assign out_o.status       = res_q.status;
  assign out_o.expired      = res_q.expired;
  assign out_o.expired_slot = res_q.expired_slot;
  assign out_o.last         = res_q.last;

endmodule

// ----- rtl/core/potb_ctrl.sv -----
// ----------------------------------------------------------------------------
// potb_ctrl: command sequencer and slot update
// Reads a slot from the state RAM, modifies it and writes it back; a tick
// sweeps all slots in order and queues expiries to the output register.
// ----------------------------------------------------------------------------
module potb_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  potb_pkg::item_t              item_i,
  output logic                         re_o,
  output logic [potb_pkg::IdxW-1:0]    rd_addr_o,
  input  logic [potb_pkg::EntryW-1:0]  rd_data_i,
  output logic                         we_o,
  output logic [potb_pkg::IdxW-1:0]    wr_addr_o,
  output logic [potb_pkg::EntryW-1:0]  wr_data_o,
  output potb_pkg::res_t               push_o,
  input  logic                         can_push_i
);

  typedef enum logic [3:0] {
    StIdle  = 4'b0001,
    StCmd   = 4'b0010,
    StSweep = 4'b0100,
    StDone  = 4'b1000
  } state_e;

  state_e                        state_q, state_d;
  logic [potb_pkg::IdxW-1:0]     cur_q, cur_d;
  logic [potb_pkg::NumTimers-1:0] wr_vld_q, wr_vld_d;
  logic                          pend_vld_q, pend_vld_d;
  logic [potb_pkg::IdxW-1:0]     pend_idx_q, pend_idx_d;
  potb_pkg::cmd_e                cmd_q;
  logic                          slot_ok_q;
  logic                          mode_q;
  logic [potb_pkg::PeriodW-1:0]  per_q;

  potb_pkg::entry_t              cur_ent, nxt_ent;
  logic [potb_pkg::PeriodW-1:0]  rem_dec;
  logic [potb_pkg::PeriodW:0]    sum;
  logic                          accept;
  logic                          expire;
  logic                          at_end;
  logic [potb_pkg::IdxW-1:0]     in_idx;

  assign in_ready_o = (state_q == StIdle);
  assign accept     = in_valid_i && in_ready_o;
  assign in_idx     = potb_pkg::IdxW'(item_i.slot);
  assign at_end     = (cur_q == potb_pkg::IdxW'(potb_pkg::NumTimers - 1));

  assign cur_ent = wr_vld_q[cur_q] ? potb_pkg::entry_t'(rd_data_i) : '0;
  assign rem_dec = (cur_ent.rem != '0) ? cur_ent.rem - 1'b1 : '0;
  assign sum     = {1'b0, cur_ent.rem} + {1'b0, cur_ent.per};
  assign expire  = cur_ent.run && (rem_dec == '0);

  always_comb begin
    state_d    = state_q;
    cur_d      = cur_q;
    wr_vld_d   = wr_vld_q;
    pend_vld_d = pend_vld_q;
    pend_idx_d = pend_idx_q;
    re_o       = 1'b0;
    rd_addr_o  = cur_q;
    we_o       = 1'b0;
    wr_addr_o  = cur_q;
    nxt_ent    = cur_ent;
    push_o     = '0;

    unique case (state_q)
      StIdle: begin
        if (accept) begin
          re_o       = 1'b1;
          pend_vld_d = 1'b0;
          if (potb_pkg::cmd_e'(item_i.cmd) == potb_pkg::CmdTick) begin
            rd_addr_o = '0;
            cur_d     = '0;
            state_d   = StSweep;
          end else begin
            rd_addr_o = in_idx;
            cur_d     = in_idx;
            state_d   = StCmd;
          end
        end
      end
      StCmd: begin
        if (can_push_i) begin
          push_o.valid  = 1'b1;
          push_o.status = potb_pkg::StOk;
          push_o.last   = 1'b1;
          if (slot_ok_q) begin
            unique case (cmd_q)
              potb_pkg::CmdInit: begin
                if (per_q == '0) begin
                  push_o.status = potb_pkg::StZeroPeriod;
                end else begin
                  we_o        = 1'b1;
                  nxt_ent.rem = '0;
                  nxt_ent.per = per_q;
                  nxt_ent.rep = mode_q;
                  nxt_ent.run = 1'b0;
                end
              end
              potb_pkg::CmdStart: begin
                if (cur_ent.per == '0) begin
                  push_o.status = potb_pkg::StUninit;
                end else begin
                  we_o        = 1'b1;
                  nxt_ent.rem = sum[potb_pkg::PeriodW] ? '1 : sum[potb_pkg::PeriodW-1:0];
                  nxt_ent.run = 1'b1;
                end
              end
              potb_pkg::CmdStop: begin
                we_o        = 1'b1;
                nxt_ent.run = 1'b0;
              end
              default: begin
                we_o = 1'b0;
              end
            endcase
          end
          state_d = StIdle;
        end
      end
      StSweep: begin
        if (can_push_i) begin
          we_o = 1'b1;
          if (cur_ent.run) begin
            nxt_ent.rem = rem_dec;
            if (expire) begin
              if (cur_ent.rep) begin
                nxt_ent.rem = cur_ent.per;
              end else begin
                nxt_ent.run = 1'b0;
              end
            end
          end
          if (expire) begin
            push_o.valid        = pend_vld_q;
            push_o.status       = potb_pkg::StOk;
            push_o.expired      = 1'b1;
            push_o.expired_slot = potb_pkg::SlotW'(pend_idx_q);
            push_o.last         = 1'b0;
            pend_vld_d          = 1'b1;
            pend_idx_d          = cur_q;
          end
          if (at_end) begin
            state_d = StDone;
          end else begin
            re_o      = 1'b1;
            rd_addr_o = cur_q + 1'b1;
            cur_d     = cur_q + 1'b1;
          end
        end
      end
      StDone: begin
        if (can_push_i) begin
          push_o.valid        = 1'b1;
          push_o.status       = potb_pkg::StOk;
          push_o.expired      = pend_vld_q;
          push_o.expired_slot = pend_vld_q ? potb_pkg::SlotW'(pend_idx_q) : '0;
          push_o.last         = 1'b1;
          state_d             = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (we_o) begin
      wr_vld_d[cur_q] = 1'b1;
    end
  end

  assign wr_data_o = nxt_ent;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      cur_q      <= '0;
      wr_vld_q   <= '0;
      pend_vld_q <= 1'b0;
      pend_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      cur_q      <= cur_d;
      wr_vld_q   <= wr_vld_d;
      pend_vld_q <= pend_vld_d;
      pend_idx_q <= pend_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= potb_pkg::cmd_e'(item_i.cmd);
      slot_ok_q <= (32'(item_i.slot) < potb_pkg::NumTimers);
      mode_q    <= item_i.repeat_mode;
      per_q     <= item_i.period_ticks;
    end
  end

endmodule

// ----- rtl/core/periodic_oneshot_timer_bank.sv -----
// ----------------------------------------------------------------------------
// periodic_oneshot_timer_bank: periodic and one-shot timer bank
// Timer slots kept in one state RAM; commands init, start, stop and tick.
//
//   channel  dir  fields                                       per transfer
//   in_i     in   cmd, slot, repeat_mode, period_ticks         one command
//   out_o    out  status, expired, expired_slot, last          one result
//
// init, start and stop go from transfer to result through a read, then an update.
// A tick does one RAM read-modify-write per slot, then the closing result.
// One command is in flight at a time; a stalled result pauses the sweep.
// Reset marks every slot unwritten; unwritten slots read as all zero.
// ----------------------------------------------------------------------------
module periodic_oneshot_timer_bank (
  input  logic        clk_i,
  input  logic        rst_ni,
  potb_in_if.sink     in_i,
  potb_out_if.source  out_o
);

  potb_pkg::item_t                   item;
  potb_pkg::res_t                    push;
  logic                              can_push;
  logic                              re;
  logic                              we;
  logic [potb_pkg::IdxW-1:0]         rd_addr;
  logic [potb_pkg::IdxW-1:0]         wr_addr;
  logic [potb_pkg::EntryW-1:0]       rd_data;
  logic [potb_pkg::EntryW-1:0]       wr_data;

  assign item.cmd          = in_i.cmd;
  assign item.slot         = in_i.slot;
  assign item.repeat_mode  = in_i.repeat_mode;
  assign item.period_ticks = in_i.period_ticks;

  potb_ram #(
    .Width(potb_pkg::EntryW),
    .Depth(potb_pkg::NumTimers)
  ) u_ram (
    .clk_i    (clk_i),
    .we_i     (we),
    .wr_addr_i(wr_addr),
    .wr_data_i(wr_data),
    .re_i     (re),
    .rd_addr_i(rd_addr),
    .rd_data_o(rd_data)
  );

  potb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_ready_o(in_i.ready),
    .item_i    (item),
    .re_o      (re),
    .rd_addr_o (rd_addr),
    .rd_data_i (rd_data),
    .we_o      (we),
    .wr_addr_o (wr_addr),
    .wr_data_o (wr_data),
    .push_o    (push),
    .can_push_i(can_push)
  );

  potb_outbuf u_outbuf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .can_push_o(can_push),
    .out_o     (out_o)
  );

endmodule

// ----- rtl/core/potb_chk.sv -----
// ----------------------------------------------------------------------------
// potb_chk: port-level checks of the timer bank
// Watches command and result transfers; bound to the top level.
// ----------------------------------------------------------------------------
module potb_chk (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_i,
  input logic                         out_valid_i,
  input logic                         out_ready_i,
  input logic [potb_pkg::StatusW-1:0] out_status_i,
  input logic                         out_expired_i,
  input logic [potb_pkg::SlotW-1:0]   out_slot_i,
  input logic                         out_last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_status_i) &&
    $stable(out_expired_i) && $stable(out_slot_i) && $stable(out_last_i))
    else $error("result changed while stalled");

  a_busy_after_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("command taken while previous one in flight");

  a_plain_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_expired_i |-> out_last_i)
    else $error("non-expiry result not marked last");

  a_error_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != potb_pkg::StOk) |-> !out_expired_i &&
    (out_slot_i == '0))
    else $error("error status on expiry result");

endmodule

bind periodic_oneshot_timer_bank potb_chk u_potb_chk (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_status_i (out_o.status),
  .out_expired_i(out_o.expired),
  .out_slot_i   (out_o.expired_slot),
  .out_last_i   (out_o.last)
);
